FILE: hw/rtl/vlmr_pkg.sv
// Shared types, codes and constants for the variable-length message ring.
package vlmr_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int LEN_W          = 9;
    localparam int WORD_W         = 32;
    localparam int STATUS_W       = 3;
    localparam int CNT_W          = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [LEN_W-1:0] MSG_BYTES_CAP = 9'd256;

    // opcodes
    localparam logic [1:0] OP_SEND_START = 2'd0;
    localparam logic [1:0] OP_SEND_DATA  = 2'd1;
    localparam logic [1:0] OP_RECEIVE    = 2'd2;
    localparam logic [1:0] OP_QUERY      = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic rx_step;    // fetch next message word, advance fetch pointer
        logic rx_end;     // fetch new head header, commit read pointer
        logic head_load;  // capture head header from store
        logic rx_out;     // a received word is on the result ports
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rx_go;
        logic [CNT_W-1:0]    rx_words;
    } t_dp_stat;

    // controller result side
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_res;

endpackage

FILE: hw/rtl/vlmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vlmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/vlmr_ctrl.sv
// Controller: accepts commands and sequences the word-by-word receive.
module vlmr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  vlmr_pkg::t_dp_stat i_stat,
    output vlmr_pkg::t_dp_cmd  o_cmd,
    output vlmr_pkg::t_res     o_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RECV  = 2'd1;
    localparam logic [1:0] S_HEAD  = 2'd2;
    localparam logic [1:0] S_HLOAD = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [vlmr_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_single, n_single;
    logic                          r_rd_vld, n_rd_vld;
    logic                          r_rd_last, n_rd_last;
    logic [vlmr_pkg::STATUS_W-1:0] r_status;
    logic                          w_accept;

    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        n_single  = w_accept && !i_stat.rx_go;
        o_cmd     = '0;
        o_cmd.accept = w_accept;
        o_cmd.rx_out = r_rd_vld;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_stat.rx_go) begin
                    n_state = S_RECV;
                    n_cnt   = i_stat.rx_words;
                end
            end
            S_RECV: begin
                o_cmd.rx_step = 1'b1;
                n_rd_vld      = 1'b1;
                n_rd_last     = (r_cnt <= 7'd1);
                n_cnt         = r_cnt - 7'd1;
                if (r_cnt <= 7'd1) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.rx_end = 1'b1;
                n_state      = S_HLOAD;
            end
            S_HLOAD: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_single  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_single  <= n_single;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= i_stat.status;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res.valid  = r_single || r_rd_vld;
    assign o_res.status = r_single ? r_status : vlmr_pkg::ST_OK;
    assign o_res.last   = r_single || r_rd_last;

    // one result source at a time
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_single && r_rd_vld))
        else $error("single result and receive word strobed together");

    a_rx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_stat.rx_go) |=> (r_state == S_RECV))
        else $error("successful receive did not enter word loop");

    a_hload_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HLOAD) |=> (r_state == S_IDLE))
        else $error("header reload did not return to idle");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |-> (r_rd_vld && r_rd_last))
        else $error("final message word not emitted when fetching next header");

endmodule

FILE: hw/rtl/vlmr_dp.sv
// Datapath: config registers, ring pointers, free count, head header shadow and store.
module vlmr_dp #(
    parameter int RING_DEPTH = vlmr_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [vlmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vlmr_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic [1:0]                       i_opcode,
    input  logic [vlmr_pkg::LEN_W-1:0]       i_message_bytes,
    input  logic [vlmr_pkg::WORD_W-1:0]      i_payload_word,
    input  vlmr_pkg::t_dp_cmd                i_cmd,
    output vlmr_pkg::t_dp_stat               o_stat,
    output logic [vlmr_pkg::WORD_W-1:0]      o_read_word,
    output logic [vlmr_pkg::LEN_W-1:0]       o_head_bytes,
    output logic [vlmr_pkg::LEN_W-1:0]       o_free_words
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = (PW + 1 > vlmr_pkg::LEN_W) ? PW + 1 : vlmr_pkg::LEN_W;
    // largest ring size the 9-bit size register can select on this store
    localparam logic [vlmr_pkg::LEN_W-1:0] DepthCap =
        (RING_DEPTH > 511) ? 9'd511 : 9'(RING_DEPTH);

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
                                          input logic [vlmr_pkg::LEN_W-1:0] size);
        logic [CW-1:0] n;
        n   = CW'(p) + CW'(1);
        adv = (n >= CW'(size)) ? '0 : n[PW-1:0];
    endfunction

    logic [8:0]                       r_ring_words, n_ring_words;
    logic [8:0]                       r_max_bytes, n_max_bytes;
    logic [PW-1:0]                    r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]                    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]                    r_rx_ptr, n_rx_ptr;
    logic [8:0]                       r_free, n_free;
    logic [vlmr_pkg::CNT_W-1:0]       r_send_left, n_send_left;
    logic [8:0]                       r_head_hdr, n_head_hdr;
    logic [8:0]                       r_rx_len, n_rx_len;

    logic [8:0]                       w_eff;
    logic                             w_empty;
    logic                             w_open;
    logic [7:0]                       w_len_dw;
    logic [9:0]                       w_need;
    logic [vlmr_pkg::CNT_W-1:0]       w_hdr_dw;
    logic [9:0]                       w_free_rx;
    logic [vlmr_pkg::STATUS_W-1:0]    w_status;
    logic                             w_rx_go;
    logic                             w_we;
    logic [PW-1:0]                    w_waddr;
    logic [vlmr_pkg::WORD_W-1:0]      w_wdata;
    logic [vlmr_pkg::WORD_W-1:0]      w_rdata;
    logic [8:0]                       w_cfg_size;

    assign w_eff     = (r_ring_words > DepthCap) ? DepthCap : r_ring_words;
    assign w_empty   = (r_free >= w_eff);
    assign w_open    = (r_send_left != '0);
    assign w_len_dw  = 8'((10'(i_message_bytes) + 10'd3) >> 2);
    assign w_need    = 10'(w_len_dw) + 10'd1;
    assign w_hdr_dw  = 7'((10'(r_head_hdr) + 10'd3) >> 2);
    assign w_free_rx = 10'(r_free) + 10'(w_hdr_dw) + 10'd1;
    assign w_cfg_size = (i_cfg_data > DepthCap) ? DepthCap : i_cfg_data;

    // verdict for the item on the input ports
    always_comb begin
        w_status = vlmr_pkg::ST_OK;
        w_rx_go  = 1'b0;
        unique case (i_opcode)
            vlmr_pkg::OP_SEND_START: begin
                if (w_open) begin
                    w_status = vlmr_pkg::ST_BUSY;
                end else if (i_message_bytes == '0 || i_message_bytes > r_max_bytes
                             || i_message_bytes > vlmr_pkg::MSG_BYTES_CAP) begin
                    w_status = vlmr_pkg::ST_BAD_LEN;
                end else if (w_need > 10'(r_free)) begin
                    w_status = vlmr_pkg::ST_NO_SPACE;
                end
            end
            vlmr_pkg::OP_SEND_DATA: begin
                if (!w_open) begin
                    w_status = vlmr_pkg::ST_NO_OPEN;
                end
            end
            vlmr_pkg::OP_RECEIVE: begin
                if (w_open) begin
                    w_status = vlmr_pkg::ST_BUSY;
                end else if (w_empty) begin
                    w_status = vlmr_pkg::ST_EMPTY;
                end else begin
                    w_rx_go = 1'b1;
                end
            end
            vlmr_pkg::OP_QUERY: begin
                w_status = vlmr_pkg::ST_OK;
            end
            default: begin
                w_status = vlmr_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_ring_words = r_ring_words;
        n_max_bytes  = r_max_bytes;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_rx_ptr     = r_rx_ptr;
        n_free       = r_free;
        n_send_left  = r_send_left;
        n_head_hdr   = r_head_hdr;
        n_rx_len     = r_rx_len;
        w_we         = 1'b0;
        w_waddr      = r_wr_ptr;
        w_wdata      = i_payload_word;

        if (i_cmd.accept && w_status == vlmr_pkg::ST_OK) begin
            case (i_opcode)
                vlmr_pkg::OP_SEND_START: begin
                    w_we        = 1'b1;
                    w_wdata     = 32'(i_message_bytes);
                    n_free      = 9'(10'(r_free) - w_need);
                    n_wr_ptr    = adv(r_wr_ptr, w_eff);
                    n_send_left = 7'(w_len_dw);
                    // header lands at the read pointer when the ring was empty
                    if (w_empty) begin
                        n_head_hdr = i_message_bytes;
                    end
                end
                vlmr_pkg::OP_SEND_DATA: begin
                    w_we        = 1'b1;
                    n_wr_ptr    = adv(r_wr_ptr, w_eff);
                    n_send_left = r_send_left - 7'd1;
                end
                vlmr_pkg::OP_RECEIVE: begin
                    n_free   = (w_free_rx > 10'(w_eff)) ? w_eff : 9'(w_free_rx);
                    n_rx_len = r_head_hdr;
                    n_rx_ptr = adv(r_rd_ptr, w_eff);
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.rx_step) begin
            n_rx_ptr = adv(r_rx_ptr, w_eff);
        end
        if (i_cmd.rx_end) begin
            n_rd_ptr = r_rx_ptr;
        end
        if (i_cmd.head_load) begin
            n_head_hdr = w_rdata[8:0];
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vlmr_pkg::CFG_RING_WORDS: begin
                    // resize empties the ring
                    n_ring_words = i_cfg_data;
                    n_rd_ptr     = '0;
                    n_wr_ptr     = '0;
                    n_send_left  = '0;
                    n_free       = w_cfg_size;
                end
                vlmr_pkg::CFG_MAX_BYTES: begin
                    n_max_bytes = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_words <= DepthCap;
            r_max_bytes  <= vlmr_pkg::MSG_BYTES_CAP;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_free       <= DepthCap;
            r_send_left  <= '0;
        end else begin
            r_ring_words <= n_ring_words;
            r_max_bytes  <= n_max_bytes;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_free       <= n_free;
            r_send_left  <= n_send_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_ptr   <= n_rx_ptr;
        r_head_hdr <= n_head_hdr;
        r_rx_len   <= n_rx_len;
    end

    vlmr_ram #(
        .WIDTH (vlmr_pkg::WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rx_ptr),
        .o_rdata (w_rdata)
    );

    assign o_stat.status   = w_status;
    assign o_stat.rx_go    = w_rx_go;
    assign o_stat.rx_words = w_hdr_dw;

    assign o_read_word  = i_cmd.rx_out ? w_rdata : '0;
    assign o_head_bytes = i_cmd.rx_out ? r_rx_len : (w_empty ? 9'd0 : r_head_hdr);
    assign o_free_words = r_free;

endmodule

FILE: hw/rtl/variable_length_message_ring_unit.sv
// Top level of the variable-length message ring: controller plus datapath.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+--------------------------------------
//  command   | start / busy                 | i_opcode, i_message_bytes, i_payload_word
//  result    | o_result_valid (strobe)      | o_status, o_read_word, o_head_bytes,
//            |                              | o_free_words, o_last
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Send start, send data, query and refused receive: one cycle per transaction, the result
// appears the cycle after it is taken and the next command may be taken in that cycle.
// Receive: result words stream one per cycle from the store's registered read port,
// then the S_HEAD and S_HLOAD states fetch the next head header; busy from acceptance until back in idle.
// Reset is synchronous, active low, and leaves the ring empty; the store is not cleared.
// Results are not back-pressured: each is valid for exactly one cycle.
module variable_length_message_ring_unit #(
    parameter int RING_DEPTH = vlmr_pkg::RING_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_opcode,
    input  logic [vlmr_pkg::LEN_W-1:0]         i_message_bytes,
    input  logic [vlmr_pkg::WORD_W-1:0]        i_payload_word,
    output logic                               o_result_valid,
    output logic [vlmr_pkg::STATUS_W-1:0]      o_status,
    output logic [vlmr_pkg::WORD_W-1:0]        o_read_word,
    output logic [vlmr_pkg::LEN_W-1:0]         o_head_bytes,
    output logic [vlmr_pkg::LEN_W-1:0]         o_free_words,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vlmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vlmr_pkg::LEN_W-1:0]         i_cfg_data
);

    vlmr_pkg::t_dp_cmd  w_cmd;
    vlmr_pkg::t_dp_stat w_stat;
    vlmr_pkg::t_res     w_res;

    vlmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_res   (w_res)
    );

    vlmr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_message_bytes (i_message_bytes),
        .i_payload_word  (i_payload_word),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_read_word     (o_read_word),
        .o_head_bytes    (o_head_bytes),
        .o_free_words    (o_free_words)
    );

    // config writes are to land only while idle; the block does not enforce it, and the port never stalls
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = w_res.valid;
    assign o_status       = w_res.status;
    assign o_last         = w_res.last;

endmodule

FILE: sim/variable_length_message_ring_unit_tb.sv
// Self-checking testbench for the variable-length message ring unit.
module variable_length_message_ring_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = vlmr_pkg::RING_DEPTH_DEF;
    localparam int N_PHASES = 9;

    typedef struct {
        logic [vlmr_pkg::STATUS_W-1:0] status;
        logic [vlmr_pkg::WORD_W-1:0]   read_word;
        logic [vlmr_pkg::LEN_W-1:0]    head_bytes;
        logic [vlmr_pkg::LEN_W-1:0]    free_words;
        logic                          last;
    } t_ring_result;

    // Mirror of the ring state; turns each accepted command into expected results.
    class t_ring_scoreboard;
        logic [vlmr_pkg::WORD_W-1:0] ring_mem [DEPTH];
        int rd_ptr;
        int wr_ptr;
        int free_cnt;
        int words_owed;
        int ring_cfg;
        int max_cfg;
        t_ring_result expected_q [$];
        int n_errors;
        int n_commands;
        int n_results;
        int n_messages;
        int n_writes;

        function new();
            ring_cfg = DEPTH;
            max_cfg  = 256;
            clear_ring();
        endfunction

        function int ring_size();
            return (ring_cfg > DEPTH) ? DEPTH : ring_cfg;
        endfunction

        function int next_ptr(int p);
            return (p + 1 >= ring_size()) ? 0 : p + 1;
        endfunction

        function int oldest_len();
            return (free_cnt >= ring_size()) ? 0
                                             : int'(ring_mem[rd_ptr][vlmr_pkg::LEN_W-1:0]);
        endfunction

        function void clear_ring();
            rd_ptr     = 0;
            wr_ptr     = 0;
            words_owed = 0;
            free_cnt   = ring_size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic [vlmr_pkg::STATUS_W-1:0] st,
                                  logic [vlmr_pkg::WORD_W-1:0] word, int hb, logic lst);
            t_ring_result r;
            r.status     = st;
            r.read_word  = word;
            r.head_bytes = hb[vlmr_pkg::LEN_W-1:0];
            r.free_words = free_cnt[vlmr_pkg::LEN_W-1:0];
            r.last       = lst;
            expected_q.push_back(r);
        endfunction

        function void set_register(logic [vlmr_pkg::CFG_IDX_W-1:0] idx,
                                   logic [vlmr_pkg::LEN_W-1:0] data);
            n_writes++;
            if (idx == vlmr_pkg::CFG_RING_WORDS) begin
                ring_cfg = int'(data);
                clear_ring();
            end else begin
                max_cfg = int'(data);
            end
        endfunction

        function void note_command(logic [1:0] op, int len, logic [vlmr_pkg::WORD_W-1:0] word);
            int dw;
            int mlen;
            int p;
            logic [vlmr_pkg::STATUS_W-1:0] st;
            n_commands++;
            case (op)
                vlmr_pkg::OP_SEND_START: begin
                    dw = (len + 3) / 4;
                    if (words_owed != 0) begin
                        st = vlmr_pkg::ST_BUSY;
                    end else if (len == 0 || len > max_cfg
                                 || len > int'(vlmr_pkg::MSG_BYTES_CAP)) begin
                        st = vlmr_pkg::ST_BAD_LEN;
                    end else if (1 + dw > free_cnt) begin
                        st = vlmr_pkg::ST_NO_SPACE;
                    end else begin
                        st = vlmr_pkg::ST_OK;
                        free_cnt -= 1 + dw;
                        ring_mem[wr_ptr] = vlmr_pkg::WORD_W'(len);
                        wr_ptr = next_ptr(wr_ptr);
                        words_owed = dw;
                    end
                    push_result(st, '0, oldest_len(), 1'b1);
                end
                vlmr_pkg::OP_SEND_DATA: begin
                    st = vlmr_pkg::ST_NO_OPEN;
                    if (words_owed != 0) begin
                        st = vlmr_pkg::ST_OK;
                        ring_mem[wr_ptr] = word;
                        wr_ptr = next_ptr(wr_ptr);
                        words_owed--;
                    end
                    push_result(st, '0, oldest_len(), 1'b1);
                end
                vlmr_pkg::OP_QUERY: begin
                    push_result(vlmr_pkg::ST_OK, '0, oldest_len(), 1'b1);
                end
                vlmr_pkg::OP_RECEIVE: begin
                    if (words_owed != 0) begin
                        push_result(vlmr_pkg::ST_BUSY, '0, oldest_len(), 1'b1);
                    end else if (free_cnt >= ring_size()) begin
                        push_result(vlmr_pkg::ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        mlen = int'(ring_mem[rd_ptr][vlmr_pkg::LEN_W-1:0]);
                        dw = (mlen + 3) / 4;
                        if (dw > 64) dw = 64;
                        free_cnt += 1 + dw;
                        if (free_cnt > ring_size()) free_cnt = ring_size();
                        p = next_ptr(rd_ptr);
                        n_messages++;
                        for (int k = 0; k < dw; k++) begin
                            push_result(vlmr_pkg::ST_OK, ring_mem[p], mlen, k == dw - 1);
                            p = next_ptr(p);
                        end
                        rd_ptr = p;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [vlmr_pkg::WORD_W-1:0] exp_v,
                                    logic [vlmr_pkg::WORD_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                n_errors++;
            end
        endfunction

        function void check_result(logic [vlmr_pkg::STATUS_W-1:0] st,
                                   logic [vlmr_pkg::WORD_W-1:0] word,
                                   logic [vlmr_pkg::LEN_W-1:0] hb,
                                   logic [vlmr_pkg::LEN_W-1:0] fw, logic lst);
            t_ring_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: status %0h word %0h", st, word);
                n_errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            n_results++;
            compare_field("status", vlmr_pkg::WORD_W'(exp_r.status),
                          vlmr_pkg::WORD_W'(st));
            compare_field("read_word", exp_r.read_word, word);
            compare_field("head_bytes", vlmr_pkg::WORD_W'(exp_r.head_bytes),
                          vlmr_pkg::WORD_W'(hb));
            compare_field("free_words", vlmr_pkg::WORD_W'(exp_r.free_words),
                          vlmr_pkg::WORD_W'(fw));
            compare_field("last", vlmr_pkg::WORD_W'(exp_r.last), vlmr_pkg::WORD_W'(lst));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     i_opcode;
    logic [vlmr_pkg::LEN_W-1:0]     i_message_bytes;
    logic [vlmr_pkg::WORD_W-1:0]    i_payload_word;
    logic                           o_result_valid;
    logic [vlmr_pkg::STATUS_W-1:0]  o_status;
    logic [vlmr_pkg::WORD_W-1:0]    o_read_word;
    logic [vlmr_pkg::LEN_W-1:0]     o_head_bytes;
    logic [vlmr_pkg::LEN_W-1:0]     o_free_words;
    logic                           o_last;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [vlmr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [vlmr_pkg::LEN_W-1:0]     i_cfg_data;

    t_ring_scoreboard sb;
    int burst_left;
    int cur_ring;
    int cur_max;
    int msgs_held;
    int phase_ring [N_PHASES] = '{256, 2, 16, 0, 7, 255, 1, 64, 256};
    int phase_max  [N_PHASES] = '{256, 4, 64, 100, 13, 200, 256, 1, 256};

    variable_length_message_ring_unit u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_message_bytes(i_message_bytes),
        .i_payload_word(i_payload_word),
        .o_result_valid(o_result_valid),
        .o_status(o_status),
        .o_read_word(o_read_word),
        .o_head_bytes(o_head_bytes),
        .o_free_words(o_free_words),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Values sampled here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result(o_status, o_read_word, o_head_bytes, o_free_words, o_last);
            if (start && !busy)
                sb.note_command(i_opcode, int'(i_message_bytes), i_payload_word);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_register(i_cfg_index, i_cfg_data);
        end
    end

    function automatic logic [vlmr_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short messages; lengths kept to the limit and, on rings of two words or more, to what the ring can hold.
    function automatic int message_length();
        int lim;
        lim = cur_max;
        if (cur_ring >= 2 && 4 * (cur_ring - 1) < lim) lim = 4 * (cur_ring - 1);
        if (lim < 1) lim = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(1, (lim < 16) ? lim : 16);
            6, 7, 8: return $urandom_range(1, lim);
            default: return lim;
        endcase
    endfunction

    task automatic issue(logic [1:0] op, int len, logic [vlmr_pkg::WORD_W-1:0] word);
        int gap;
        start           <= 1'b1;
        i_opcode        <= op;
        i_message_bytes <= len[vlmr_pkg::LEN_W-1:0];
        i_payload_word  <= word;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                i_message_bytes <= vlmr_pkg::LEN_W'($urandom_range(0, 256));
                i_payload_word  <= $urandom;
                @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Block idle: nothing outstanding, not busy, plus a short settle.
    task automatic wait_idle();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [vlmr_pkg::CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[vlmr_pkg::LEN_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == vlmr_pkg::CFG_RING_WORDS) begin
            cur_ring  = data;
            msgs_held = 0;
        end else begin
            cur_max = data;
        end
    endtask

    task automatic run_phase(int ring_w, int max_b, int n_items);
        int done;
        int pick;
        int rx_pct;
        int len;
        int dw;
        int cut;
        wait_idle();
        write_register(vlmr_pkg::CFG_RING_WORDS, ring_w);
        write_register(vlmr_pkg::CFG_MAX_BYTES, max_b);
        done = 0;
        while (done < n_items) begin
            pick   = $urandom_range(0, 99);
            rx_pct = (msgs_held > 3) ? 45 : 20;
            if (pick < rx_pct) begin
                issue(vlmr_pkg::OP_RECEIVE, $urandom_range(0, 256), $urandom);
                if (msgs_held > 0) msgs_held--;
                done++;
            end else if (pick < 85) begin
                len = message_length();
                dw  = (len + 3) / 4;
                issue(vlmr_pkg::OP_SEND_START, len, $urandom);
                for (int k = 0; k < dw; k++)
                    issue(vlmr_pkg::OP_SEND_DATA, $urandom_range(0, 256), rand_word());
                msgs_held++;
                done += 1 + dw;
            end else if (pick < 89) begin
                issue(vlmr_pkg::OP_QUERY, $urandom_range(0, 256), $urandom);
                done++;
            end else if (pick < 93) begin
                issue(vlmr_pkg::OP_SEND_DATA, $urandom_range(0, 256), rand_word());
                done++;
            end else if (pick < 96) begin
                len = (cur_max < 256 && $urandom_range(0, 1))
                    ? $urandom_range(cur_max + 1, 256) : 0;
                issue(vlmr_pkg::OP_SEND_START, len, $urandom);
                done++;
            end else begin
                // interrupted send: a receive or a second start lands mid-message
                len = message_length();
                dw  = (len + 3) / 4;
                cut = $urandom_range(0, dw - 1);
                issue(vlmr_pkg::OP_SEND_START, len, $urandom);
                for (int k = 0; k < cut; k++) issue(vlmr_pkg::OP_SEND_DATA, 0, rand_word());
                if ($urandom_range(0, 1))
                    issue(vlmr_pkg::OP_RECEIVE, 0, $urandom);
                else
                    issue(vlmr_pkg::OP_SEND_START, $urandom_range(0, 256), $urandom);
                for (int k = cut; k < dw; k++) issue(vlmr_pkg::OP_SEND_DATA, 0, rand_word());
                msgs_held++;
                done += 2 + dw;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = vlmr_pkg::OP_QUERY;
        i_message_bytes = '0;
        i_payload_word  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = vlmr_pkg::CFG_RING_WORDS;
        i_cfg_data      = '0;
        burst_left      = 0;
        cur_ring        = DEPTH;
        cur_max         = 256;
        msgs_held       = 0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, stray word, zero length, open send blocking receive and start
        issue(vlmr_pkg::OP_QUERY, 0, '0);
        issue(vlmr_pkg::OP_RECEIVE, 0, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, '1);
        issue(vlmr_pkg::OP_SEND_START, 0, '0);
        issue(vlmr_pkg::OP_SEND_START, 256, '0);
        issue(vlmr_pkg::OP_RECEIVE, 0, '0);
        issue(vlmr_pkg::OP_SEND_START, 5, '0);
        issue(vlmr_pkg::OP_QUERY, 0, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, '1);

        // resize drops the open send; then length limit
        wait_idle();
        write_register(vlmr_pkg::CFG_RING_WORDS, DEPTH);
        write_register(vlmr_pkg::CFG_MAX_BYTES, 12);
        issue(vlmr_pkg::OP_SEND_START, 13, '0);
        issue(vlmr_pkg::OP_SEND_START, 12, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, '1);
        issue(vlmr_pkg::OP_SEND_DATA, 0, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, 32'h5A5A_A5A5);
        issue(vlmr_pkg::OP_RECEIVE, 0, '0);
        issue(vlmr_pkg::OP_SEND_START, 1, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, 32'h8000_0001);
        issue(vlmr_pkg::OP_RECEIVE, 0, '0);

        // zero-size ring refuses sends and receives; a query still answers OK
        wait_idle();
        write_register(vlmr_pkg::CFG_RING_WORDS, 0);
        issue(vlmr_pkg::OP_SEND_START, 1, '0);
        issue(vlmr_pkg::OP_RECEIVE, 0, '0);
        issue(vlmr_pkg::OP_QUERY, 0, '0);
        issue(vlmr_pkg::OP_SEND_DATA, 0, '1);

        for (int i = 0; i < N_PHASES; i++) run_phase(phase_ring[i], phase_max[i], 48);

        wait_idle();
        repeat (70) @(posedge i_clk);
        $display("covered %0d commands and %0d result words, %0d messages read back",
                 sb.n_commands, sb.n_results, sb.n_messages);
        $display("over %0d register writes, ring sizes 0 to %0d", sb.n_writes, DEPTH);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("variable_length_message_ring_unit_tb: done, clean");
        end else begin
            $display("variable_length_message_ring_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("variable_length_message_ring_unit_tb: done, errors");
        $finish;
    end

endmodule
